>>> hdl/ats7_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ats7_pkg;

   localparam int TICK_W = 32;
   localparam int SEG_W  = 8;

   // ticks at or above this are 3600 s and more
   localparam logic [TICK_W-1:0] READY_TICKS = 32'd36_000_000;

   // reciprocal constants, each exact over the operand range it is used on
   localparam logic [26:0] RECIP_100_K33 = 27'd85_899_346;  // 26-bit n / 100
   localparam logic [19:0] RECIP_10_K23  = 20'd838_861;     // 20-bit n / 10
   localparam logic [16:0] RECIP_10_K20  = 17'd104_858;     // 16-bit n / 10
   localparam logic [12:0] RECIP_60_K18  = 13'd4_370;       // 12-bit n / 60

   // layout codes
   localparam logic [1:0] LAY_S_HH  = 2'd0;   // s.hh, top digit blank
   localparam logic [1:0] LAY_SS_HH = 2'd1;   // ss.hh
   localparam logic [1:0] LAY_M_SS_T = 2'd2;  // m.ss.t
   localparam logic [1:0] LAY_MM_SS = 2'd3;   // mm.ss

   localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;
   localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
   localparam logic [SEG_W-1:0] SEG_R     = 8'h50;
   localparam logic [SEG_W-1:0] SEG_D     = 8'h5e;
   localparam logic [SEG_W-1:0] SEG_Y     = 8'h6e;

   function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
      logic [SEG_W-1:0] code;
      case (digit)
         4'd0: code = 8'h3f;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5b;
         4'd3: code = 8'h4f;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6d;
         4'd6: code = 8'h7d;
         4'd7: code = 8'h07;
         4'd8: code = 8'h7f;
         4'd9: code = 8'h6f;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

   // tens digit of a value below 64
   function automatic logic [2:0] tens_of(input logic [5:0] n);
      logic [2:0] t;
      if (n >= 6'd60) begin
         t = 3'd6;
      end else if (n >= 6'd50) begin
         t = 3'd5;
      end else if (n >= 6'd40) begin
         t = 3'd4;
      end else if (n >= 6'd30) begin
         t = 3'd3;
      end else if (n >= 6'd20) begin
         t = 3'd2;
      end else if (n >= 6'd10) begin
         t = 3'd1;
      end else begin
         t = 3'd0;
      end
      return t;
   endfunction

endpackage

`default_nettype wire

>>> hdl/autorange_time_to_seven_segment_core.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_tick_count[31:0]
// rsp     | out       | rsp_valid, rsp_stall | rsp_digit0..3_segments[7:0], rsp_showing_ready
//
// seven register stages: a count is accepted every cycle unless rsp is stalled,
// and reaches rsp from stage 7; the chain of reciprocal multiplies sets the depth
// reset clears the stage valid bits only; payload registers are not reset
// a stalled result freezes the whole pipeline, and req_stall follows at once
`timescale 1ns / 1ps
`default_nettype none

module autorange_time_to_seven_segment_core
   import ats7_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [TICK_W-1:0] req_tick_count,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [SEG_W-1:0]       rsp_digit0_segments,
   output logic [SEG_W-1:0]       rsp_digit1_segments,
   output logic [SEG_W-1:0]       rsp_digit2_segments,
   output logic [SEG_W-1:0]       rsp_digit3_segments,
   output logic                   rsp_showing_ready
);

   logic adv;
   logic [6:0] valid_ff, valid_in;

   // stage 1: centiseconds
   logic        s1_ready_ff;
   logic [18:0] s1_cs_ff;
   logic [52:0] s1_prod;
   // stage 2: tenths of a second
   logic        s2_ready_ff;
   logic [3:0]  s2_cs_lo_ff;
   logic [15:0] s2_ds_ff;
   logic [39:0] s2_prod;
   // stage 3: seconds, hundredths
   logic        s3_ready_ff;
   logic [11:0] s3_sec_ff;
   logic [3:0]  s3_ds_lo_ff;
   logic [3:0]  s3_hun_ff;
   logic [32:0] s3_prod;
   // stage 4: minutes, tenths, layout
   logic        s4_ready_ff;
   logic [5:0]  s4_mins_ff;
   logic [5:0]  s4_sec_lo_ff;
   logic [3:0]  s4_ten_ff;
   logic [3:0]  s4_hun_ff;
   logic [1:0]  s4_lay_ff;
   logic [1:0]  s4_lay_in;
   logic [24:0] s4_prod;
   // stage 5: remaining seconds
   logic        s5_ready_ff;
   logic [5:0]  s5_rem_ff;
   logic [5:0]  s5_mins_ff;
   logic [5:0]  s5_sec_lo_ff;
   logic [3:0]  s5_ten_ff;
   logic [3:0]  s5_hun_ff;
   logic [1:0]  s5_lay_ff;
   // stage 6: decimal digits
   logic        s6_ready_ff;
   logic [2:0]  s6_sec_t_ff, s6_min_t_ff, s6_rem_t_ff;
   logic [3:0]  s6_sec_o_ff, s6_min_o_ff, s6_rem_o_ff;
   logic [3:0]  s6_ten_ff;
   logic [3:0]  s6_hun_ff;
   logic [1:0]  s6_lay_ff;
   logic [2:0]  s6_sec_t_in, s6_min_t_in, s6_rem_t_in;
   // stage 7: segment bytes
   logic [SEG_W-1:0] d0_ff, d1_ff, d2_ff, d3_ff;
   logic [SEG_W-1:0] d0_in, d1_in, d2_in, d3_in;
   logic             rdy_ff;

   assign adv       = !(valid_ff[6] && rsp_stall);
   assign req_stall = !adv;
   assign valid_in  = {valid_ff[5:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   assign s1_prod = req_tick_count[25:0] * RECIP_100_K33;
   assign s2_prod = {1'b0, s1_cs_ff} * RECIP_10_K23;
   assign s3_prod = s2_ds_ff * RECIP_10_K20;
   assign s4_prod = s3_sec_ff * RECIP_60_K18;

   always_comb begin
      if (s3_sec_ff < 12'd10) begin
         s4_lay_in = LAY_S_HH;
      end else if (s3_sec_ff < 12'd60) begin
         s4_lay_in = LAY_SS_HH;
      end else if (s3_sec_ff < 12'd600) begin
         s4_lay_in = LAY_M_SS_T;
      end else begin
         s4_lay_in = LAY_MM_SS;
      end
   end

   assign s6_sec_t_in = tens_of(s5_sec_lo_ff);
   assign s6_min_t_in = tens_of(s5_mins_ff);
   assign s6_rem_t_in = tens_of(s5_rem_ff);

   always_comb begin
      d3_in = SEG_BLANK;
      d2_in = SEG_BLANK;
      d1_in = SEG_BLANK;
      d0_in = SEG_BLANK;
      case (s6_lay_ff)
         LAY_S_HH: begin
            d2_in = seg_of(s6_sec_o_ff) | SEG_DP;
            d1_in = seg_of(s6_ten_ff);
            d0_in = seg_of(s6_hun_ff);
         end
         LAY_SS_HH: begin
            d3_in = seg_of({1'b0, s6_sec_t_ff});
            d2_in = seg_of(s6_sec_o_ff) | SEG_DP;
            d1_in = seg_of(s6_ten_ff);
            d0_in = seg_of(s6_hun_ff);
         end
         LAY_M_SS_T: begin
            d3_in = seg_of(s6_min_o_ff) | SEG_DP;
            d2_in = seg_of({1'b0, s6_rem_t_ff});
            d1_in = seg_of(s6_rem_o_ff) | SEG_DP;
            d0_in = seg_of(s6_ten_ff);
         end
         LAY_MM_SS: begin
            d3_in = seg_of({1'b0, s6_min_t_ff});
            d2_in = seg_of(s6_min_o_ff) | SEG_DP;
            d1_in = seg_of({1'b0, s6_rem_t_ff});
            d0_in = seg_of(s6_rem_o_ff);
         end
         default: begin
            d0_in = SEG_BLANK;
         end
      endcase
      if (s6_ready_ff) begin
         d3_in = SEG_BLANK;
         d2_in = SEG_R;
         d1_in = SEG_D;
         d0_in = SEG_Y;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ready_ff  <= (req_tick_count >= READY_TICKS);
         s1_cs_ff     <= s1_prod[51:33];

         s2_ready_ff  <= s1_ready_ff;
         s2_cs_lo_ff  <= s1_cs_ff[3:0];
         s2_ds_ff     <= s2_prod[38:23];

         s3_ready_ff  <= s2_ready_ff;
         s3_sec_ff    <= s3_prod[31:20];
         s3_ds_lo_ff  <= s2_ds_ff[3:0];
         // remainders only need the low bits, differences wrap mod 16
         s3_hun_ff    <= s2_cs_lo_ff - 4'(s2_ds_ff[3:0] * 4'd10);

         s4_ready_ff  <= s3_ready_ff;
         s4_mins_ff   <= s4_prod[23:18];
         s4_sec_lo_ff <= s3_sec_ff[5:0];
         s4_ten_ff    <= s3_ds_lo_ff - 4'(s3_sec_ff[3:0] * 4'd10);
         s4_hun_ff    <= s3_hun_ff;
         s4_lay_ff    <= s4_lay_in;

         s5_ready_ff  <= s4_ready_ff;
         s5_rem_ff    <= s4_sec_lo_ff - 6'(s4_mins_ff * 6'd60);
         s5_mins_ff   <= s4_mins_ff;
         s5_sec_lo_ff <= s4_sec_lo_ff;
         s5_ten_ff    <= s4_ten_ff;
         s5_hun_ff    <= s4_hun_ff;
         s5_lay_ff    <= s4_lay_ff;

         s6_ready_ff  <= s5_ready_ff;
         s6_sec_t_ff  <= s6_sec_t_in;
         s6_min_t_ff  <= s6_min_t_in;
         s6_rem_t_ff  <= s6_rem_t_in;
         s6_sec_o_ff  <= s5_sec_lo_ff[3:0] - 4'({1'b0, s6_sec_t_in} * 4'd10);
         s6_min_o_ff  <= s5_mins_ff[3:0] - 4'({1'b0, s6_min_t_in} * 4'd10);
         s6_rem_o_ff  <= s5_rem_ff[3:0] - 4'({1'b0, s6_rem_t_in} * 4'd10);
         s6_ten_ff    <= s5_ten_ff;
         s6_hun_ff    <= s5_hun_ff;
         s6_lay_ff    <= s5_lay_ff;

         d0_ff        <= d0_in;
         d1_ff        <= d1_in;
         d2_ff        <= d2_in;
         d3_ff        <= d3_in;
         rdy_ff       <= s6_ready_ff;
      end
   end

   assign rsp_valid           = valid_ff[6];
   assign rsp_digit0_segments = d0_ff;
   assign rsp_digit1_segments = d1_ff;
   assign rsp_digit2_segments = d2_ff;
   assign rsp_digit3_segments = d3_ff;
   assign rsp_showing_ready   = rdy_ff;

   // reciprocal results stay in digit range for every time layout
   a_hun_ten_digits: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] && !s5_ready_ff |-> s5_hun_ff < 4'd10 && s5_ten_ff < 4'd10)
      else $error("hundredths or tenths out of digit range");

   a_min_rem_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] && !s5_ready_ff |-> s5_rem_ff < 6'd60 && s5_mins_ff < 6'd60)
      else $error("minutes or seconds remainder out of range");

   a_ready_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_showing_ready |-> rsp_digit3_segments == SEG_BLANK
         && rsp_digit2_segments == SEG_R && rsp_digit1_segments == SEG_D
         && rsp_digit0_segments == SEG_Y)
      else $error("ready pattern wrong");

   a_digit0_no_dp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_digit0_segments[7])
      else $error("decimal point on rightmost digit");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted transaction did not enter the pipeline");

endmodule

`default_nettype wire
